// ===== design/plob_pkg.sv =====
`default_nettype none

package plob_pkg;

   localparam int LEVELS_PER_SIDE = 64;
   localparam int PRICE_W         = 31;
   localparam int QTY_W           = 48;
   localparam int IN_QTY_W        = 32;

   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } level_type;

   // compare strobe comes with the accepted beat, update in the cycle after it
   typedef struct packed {
      logic                cmp_en;
      logic [PRICE_W-1:0]  cmp_price;
      logic [IN_QTY_W-1:0] cmp_qty;
      logic                upd_en;
      logic                upd_reduce;
      logic [PRICE_W-1:0]  upd_price;
      logic [IN_QTY_W-1:0] upd_qty;
   } side_ctrl_type;

   typedef struct packed {
      level_type best;
      logic      drop;
   } side_stat_type;

endpackage

`default_nettype wire

// ===== design/plob_cell.sv =====
`default_nettype none

module plob_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  plob_pkg::side_ctrl_type ctrl,
   input  wire                   low_first,
   input  wire                   any_match,
   input  wire                   any_rm,
   input  wire                   full,
   input  plob_pkg::level_type   left_level,
   input  wire                   left_better,
   input  plob_pkg::level_type   right_level,
   output plob_pkg::level_type   level_q,
   output logic                  better_q,
   output logic                  match_q,
   output logic                  rm_q
);

   logic                          valid_ff, valid_in;
   logic [plob_pkg::PRICE_W-1:0]  price_ff, price_in;
   logic [plob_pkg::QTY_W-1:0]    qty_ff, qty_in;
   logic                          better_ff, better_in;
   logic                          match_ff, match_in;
   logic                          rm_ff, rm_in;
   logic [plob_pkg::QTY_W:0]      sum;
   logic                          hit;

   assign hit = valid_ff && (price_ff == ctrl.cmp_price);
   assign sum = (plob_pkg::QTY_W+1)'(qty_ff) + (plob_pkg::QTY_W+1)'(ctrl.upd_qty);

   always_comb begin
      better_in = better_ff;
      match_in  = match_ff;
      rm_in     = rm_ff;
      if (ctrl.cmp_en) begin
         // levels stay sorted with the best price in the first cell
         better_in = valid_ff && (low_first ? (price_ff < ctrl.cmp_price)
                                            : (price_ff > ctrl.cmp_price));
         match_in  = hit;
         rm_in     = hit && (qty_ff <= plob_pkg::QTY_W'(ctrl.cmp_qty));
      end
   end

   always_comb begin
      valid_in = valid_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      if (ctrl.upd_en) begin
         if (!ctrl.upd_reduce) begin
            if (any_match) begin
               if (match_ff) begin
                  qty_in = sum[plob_pkg::QTY_W] ? {plob_pkg::QTY_W{1'b1}}
                                                : sum[plob_pkg::QTY_W-1:0];
               end
            end else if (!full && !better_ff) begin
               if (left_better) begin
                  // insertion point
                  valid_in = 1'b1;
                  price_in = ctrl.upd_price;
                  qty_in   = plob_pkg::QTY_W'(ctrl.upd_qty);
               end else begin
                  valid_in = left_level.valid;
                  price_in = left_level.price;
                  qty_in   = left_level.qty;
               end
            end
         end else begin
            if (any_rm) begin
               // close the gap left by the removed level
               if (!better_ff) begin
                  valid_in = right_level.valid;
                  price_in = right_level.price;
                  qty_in   = right_level.qty;
               end
            end else if (match_ff) begin
               qty_in = qty_ff - plob_pkg::QTY_W'(ctrl.upd_qty);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         better_ff <= 1'b0;
         match_ff  <= 1'b0;
         rm_ff     <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         better_ff <= better_in;
         match_ff  <= match_in;
         rm_ff     <= rm_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end

   assign level_q  = '{valid: valid_ff, price: price_ff, qty: qty_ff};
   assign better_q = better_ff;
   assign match_q  = match_ff;
   assign rm_q     = rm_ff;

endmodule

`default_nettype wire

// ===== design/plob_side.sv =====
`default_nettype none

module plob_side (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     low_first,
   input  plob_pkg::side_ctrl_type ctrl,
   output plob_pkg::side_stat_type stat
);

   localparam int N = plob_pkg::LEVELS_PER_SIDE;

   plob_pkg::level_type lv [N];
   logic [N-1:0]        better_v;
   logic [N-1:0]        match_v;
   logic [N-1:0]        rm_v;
   logic                any_match;
   logic                any_rm;
   logic                full;

   assign any_match = |match_v;
   assign any_rm    = |rm_v;
   assign full      = lv[N-1].valid;

   for (genvar i = 0; i < N; i++) begin : g_cell
      plob_pkg::level_type left_lv;
      plob_pkg::level_type right_lv;
      logic                left_bt;

      if (i == 0) begin : g_head
         assign left_lv = '0;
         assign left_bt = 1'b1;
      end else begin : g_mid
         assign left_lv = lv[i-1];
         assign left_bt = better_v[i-1];
      end

      if (i == N-1) begin : g_tail
         assign right_lv = '0;
      end else begin : g_body
         assign right_lv = lv[i+1];
      end

      plob_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .low_first   (low_first),
         .any_match   (any_match),
         .any_rm      (any_rm),
         .full        (full),
         .left_level  (left_lv),
         .left_better (left_bt),
         .right_level (right_lv),
         .level_q     (lv[i]),
         .better_q    (better_v[i]),
         .match_q     (match_v[i]),
         .rm_q        (rm_v[i])
      );
   end

   assign stat.best = lv[0];
   assign stat.drop = ctrl.upd_en && !ctrl.upd_reduce && !any_match && full;

endmodule

`default_nettype wire

// ===== design/price_level_order_book_top.sv =====
// flow: the rows compare with the input beat when it is accepted, shift in S_UPD,
//    and the result beat is registered out of S_RPT; a new beat is taken only in
//    S_IDLE or in S_RPT once the output is free, so items never overlap; while a
//    result beat is stalled the finished item waits in S_RPT and the input stays blocked
// reset: clears every level valid bit, both last reported prices and the
//    handshake state; level prices and quantities are left as they are
`default_nettype none

module price_level_order_book_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [63:0]  req_tdata,  // price[30:0], quantity[62:31], zero[63]
   input  wire  [1:0]   req_tuser,  // command[0], side[1]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [159:0] rsp_tdata,  // best_bid_price, best_bid_qty, best_ask_price,
                                    // best_ask_qty, zero[159:158]
   output logic [3:0]   rsp_tuser   // both_sides_present, bid_changed, ask_changed,
                                    // level_dropped
);

   localparam int PW = plob_pkg::PRICE_W;
   localparam int QW = plob_pkg::QTY_W;
   localparam int IW = plob_pkg::IN_QTY_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPD,
      S_RPT
   } state_type;

   state_type     state_ff, state_in;
   logic          accept;
   logic          out_free;
   logic          load;
   logic          cmd_ff;
   logic          side_ff;
   logic [PW-1:0] price_ff;
   logic [IW-1:0] qty_ff;
   logic          dropped_ff;
   logic [PW-1:0] last_bid_ff;
   logic [PW-1:0] last_ask_ff;
   logic          rsp_valid_ff;
   logic [159:0]  rsp_data_ff;
   logic [3:0]    rsp_user_ff;

   plob_pkg::side_ctrl_type bid_ctrl, ask_ctrl;
   plob_pkg::side_stat_type bid_stat, ask_stat;

   logic [PW-1:0] bid_p, ask_p;
   logic [QW-1:0] bid_q, ask_q;
   logic          both, bid_chg, ask_chg;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_RPT) && out_free);
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == S_RPT) && out_free;

   always_comb begin
      bid_ctrl.cmp_en     = accept && !req_tuser[1];
      bid_ctrl.cmp_price  = req_tdata[30:0];
      bid_ctrl.cmp_qty    = req_tdata[62:31];
      bid_ctrl.upd_en     = (state_ff == S_UPD) && !side_ff;
      bid_ctrl.upd_reduce = cmd_ff;
      bid_ctrl.upd_price  = price_ff;
      bid_ctrl.upd_qty    = qty_ff;
      ask_ctrl            = bid_ctrl;
      ask_ctrl.cmp_en     = accept && req_tuser[1];
      ask_ctrl.upd_en     = (state_ff == S_UPD) && side_ff;
   end

   plob_side u_bid (
      .clock     (clock),
      .reset     (reset),
      .low_first (1'b0),
      .ctrl      (bid_ctrl),
      .stat      (bid_stat)
   );

   plob_side u_ask (
      .clock     (clock),
      .reset     (reset),
      .low_first (1'b1),
      .ctrl      (ask_ctrl),
      .stat      (ask_stat)
   );

   // first cell of each row holds the best level
   always_comb begin
      bid_p   = bid_stat.best.valid ? bid_stat.best.price : '0;
      bid_q   = bid_stat.best.valid ? bid_stat.best.qty : '0;
      ask_p   = ask_stat.best.valid ? ask_stat.best.price : '0;
      ask_q   = ask_stat.best.valid ? ask_stat.best.qty : '0;
      both    = bid_stat.best.valid && ask_stat.best.valid;
      bid_chg = both && (bid_p != last_bid_ff);
      ask_chg = both && (ask_p != last_ask_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            state_in = S_RPT;
         end
         S_RPT: begin
            if (load) begin
               state_in = accept ? S_UPD : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         rsp_user_ff  <= '0;
         last_bid_ff  <= '0;
         last_ask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {2'b00, ask_q, ask_p, bid_q, bid_p};
            rsp_user_ff  <= {dropped_ff, ask_chg, bid_chg, both};
            if (bid_chg) begin
               last_bid_ff <= bid_p;
            end
            if (ask_chg) begin
               last_ask_ff <= ask_p;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser[0];
         side_ff  <= req_tuser[1];
         price_ff <= req_tdata[30:0];
         qty_ff   <= req_tdata[62:31];
      end
      if (state_ff == S_UPD) begin
         dropped_ff <= bid_stat.drop || ask_stat.drop;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== design/plob_checker.sv =====
`default_nettype none

module plob_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire [63:0]  req_tdata,
   input wire [1:0]   req_tuser,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [159:0] rsp_tdata,
   input wire [3:0]   rsp_tuser
);

   // a stalled result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // change flags only while both sides hold levels
   a_bid_chg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("bid change flagged with a side empty");

   a_ask_chg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[0])
      else $error("ask change flagged with a side empty");

   // no input beat is taken while the rows update (S_UPD) for the last one
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input beat taken in the update cycle");

endmodule

bind price_level_order_book_top plob_checker u_plob_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
